@@ rtl/pnt_pkg.sv @@
// pnt_pkg: shared constants for the piano-roll note tracker.
// No dependencies; imported by pianoroll_note_tracker.
`timescale 1ns / 1ps

package pnt_pkg;

    localparam int PITCH_COUNT_DEF    = 88;
    localparam int FRAME_BITS_DEF     = 16;

    localparam int CMD_W              = 1;
    localparam int PITCH_W            = 7;
    localparam int NOTE_W             = 8;
    localparam int TIME_W             = 16;

    localparam logic [PITCH_W-1:0] LOWEST_PITCH_RST = 7'd21;

    localparam logic [CMD_W-1:0] CMD_CELL  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

endpackage

@@ rtl/pnt_ram.sv @@
// pnt_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pnt_ram #(
    parameter int WIDTH  = 18,
    parameter int DEPTH  = 88,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pianoroll_note_tracker.sv @@
// pianoroll_note_tracker: turns piano-roll cells into finished notes.
// Depends on pnt_pkg and pnt_ram.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_ready): one beat per piano-roll cell, or
//   a clear command (i_cmd = CMD_CLEAR) that resets all per-pitch state and the
//   frame counter. i_last_in_frame on a cell advances the frame counter after
//   that cell is handled; the counter saturates at all ones.
//   Output channel (o_out_valid / i_out_ready): one beat per finished note:
//   note number, start frame and duration in frames.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): writes
//   lowest_pitch; write it only while the block is idle.
// Timing
//   One cell per clock sustained while the output is not stalled. A note
//   that a cell closes passes the per-pitch RAM read (stage 1), then the
//   update and the output register.
//   The per-pitch RAM is read on accept and written back when stage 1 moves on;
//   a cell that hits the pitch written in the same cycle takes forwarded data.
// Reset / stall
//   Reset clears the pipeline, the per-pitch valid bits (so every pitch reads
//   closed with no prior onset) and the frame counter; no clearing pass.
//   When the receiver stalls with a note held, the update stage waits and the
//   input stops after one more beat has been taken into the read stage.

module pianoroll_note_tracker
    #(
    parameter int PITCH_COUNT = pnt_pkg::PITCH_COUNT_DEF,
    parameter int FRAME_BITS  = pnt_pkg::FRAME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pnt_pkg::PITCH_W-1:0]  i_cfg_data,
    // input cells
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pnt_pkg::CMD_W-1:0]    i_cmd,
    input  logic [pnt_pkg::PITCH_W-1:0]  i_pitch_index,
    input  logic                         i_frame_bit,
    input  logic                         i_onset_bit,
    input  logic                         i_last_in_frame,
    // finished notes
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pnt_pkg::NOTE_W-1:0]   o_note_pitch,
    output logic [pnt_pkg::TIME_W-1:0]   o_start_frame,
    output logic [pnt_pkg::TIME_W-1:0]   o_duration_frames
);

    import pnt_pkg::*;

    localparam int AW    = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
    localparam int ENT_W = FRAME_BITS + 2;     // {open, prior, start}
    localparam logic [FRAME_BITS-1:0] FC_MAX = {FRAME_BITS{1'b1}};

    // config register
    logic [PITCH_W-1:0] r_lowest;

    // stage 1 (RAM data valid)
    logic                r_s1_vld;
    logic [CMD_W-1:0]    r_s1_cmd;
    logic [PITCH_W-1:0]  r_s1_idx;
    logic                r_s1_fr;
    logic                r_s1_on;
    logic                r_s1_last;
    logic                r_s1_inr;
    logic                r_fwd;
    logic [ENT_W-1:0]    r_fwd_data;

    // per-pitch valid bits, frame counter
    logic [PITCH_COUNT-1:0] r_ent_vld;
    logic [PITCH_COUNT-1:0] n_ent_vld;
    logic [FRAME_BITS-1:0]  r_fc;
    logic [FRAME_BITS-1:0]  n_fc;

    // output register
    logic                r_out_vld;
    logic [NOTE_W-1:0]   r_note_pitch;
    logic [TIME_W-1:0]   r_start_frame;
    logic [TIME_W-1:0]   r_duration;

    logic                in_acc;
    logic                out_free;
    logic                s1_go;
    logic                s1_we;
    logic                s1_emit;
    logic [AW-1:0]       s1_addr;
    logic [ENT_W-1:0]    ram_q;
    logic [ENT_W-1:0]    s1_ent;
    logic                s1_open;
    logic                s1_prior;
    logic [FRAME_BITS-1:0] s1_start;
    logic                n_open;
    logic [FRAME_BITS-1:0] n_start;
    logic [ENT_W-1:0]    s1_wdata;
    logic [FRAME_BITS-1:0] s1_dur;
    logic [31:0]         start_ext;
    logic [31:0]         dur_ext;
    logic                in_range;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_vld || i_out_ready;
    assign s1_go      = r_s1_vld && out_free;
    assign o_in_ready = !r_s1_vld || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, i_pitch_index} < (PITCH_W + 1)'(PITCH_COUNT);
    assign s1_addr    = r_s1_idx[AW-1:0];
    assign s1_we      = s1_go && (r_s1_cmd == CMD_CELL) && r_s1_inr;

    pnt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PITCH_COUNT),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (s1_we),
        .i_waddr(s1_addr),
        .i_wdata(s1_wdata),
        .i_re   (in_acc),
        .i_raddr(i_pitch_index[AW-1:0]),
        .o_rdata(ram_q)
    );

    // entry as seen by stage 1: forwarded write wins over stale RAM data,
    // an entry without its valid bit reads closed with no prior onset
    always_comb begin
        s1_ent   = r_fwd ? r_fwd_data : ram_q;
        s1_open  = r_ent_vld[s1_addr] && s1_ent[ENT_W-1];
        s1_prior = r_ent_vld[s1_addr] && s1_ent[ENT_W-2];
        s1_start = s1_ent[FRAME_BITS-1:0];
    end

    // note rules
    always_comb begin
        n_open  = s1_open;
        n_start = s1_start;
        s1_emit = 1'b0;
        if (r_s1_fr) begin
            if (s1_open) begin
                if (r_s1_on && !s1_prior) begin
                    s1_emit = 1'b1;
                    n_start = r_fc;
                end
            end else if (r_s1_on) begin
                n_open  = 1'b1;
                n_start = r_fc;
            end
        end else if (s1_open) begin
            s1_emit = 1'b1;
            n_open  = 1'b0;
        end
        if (!r_s1_inr || (r_s1_cmd != CMD_CELL)) begin
            s1_emit = 1'b0;
        end
        s1_wdata  = {n_open, r_s1_on, n_start};
        s1_dur    = r_fc - s1_start;
        start_ext = 32'(s1_start);
        dur_ext   = 32'(s1_dur);
    end

    // valid bits and frame counter
    always_comb begin
        n_ent_vld = r_ent_vld;
        n_fc      = r_fc;
        if (s1_go) begin
            if (r_s1_cmd == CMD_CLEAR) begin
                n_ent_vld = '0;
                n_fc      = '0;
            end else begin
                if (s1_we) begin
                    n_ent_vld[s1_addr] = 1'b1;
                end
                if (r_s1_last && (r_fc != FC_MAX)) begin
                    n_fc = r_fc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= LOWEST_PITCH_RST;
            r_s1_vld  <= 1'b0;
            r_fwd     <= 1'b0;
            r_ent_vld <= '0;
            r_fc      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_lowest <= i_cfg_data;
            end
            r_ent_vld <= n_ent_vld;
            r_fc      <= n_fc;
            if (in_acc) begin
                r_s1_vld <= 1'b1;
                // same pitch written this edge: RAM read returns stale data
                r_fwd    <= s1_we && (r_s1_idx == i_pitch_index);
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
                r_fwd    <= 1'b0;
            end
            if (s1_go && s1_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= i_cmd;
            r_s1_idx   <= i_pitch_index;
            r_s1_fr    <= i_frame_bit;
            r_s1_on    <= i_onset_bit;
            r_s1_last  <= i_last_in_frame;
            r_s1_inr   <= in_range;
            r_fwd_data <= s1_wdata;
        end
        if (s1_go && s1_emit) begin
            r_note_pitch  <= {1'b0, r_lowest} + {1'b0, r_s1_idx};
            r_start_frame <= start_ext[TIME_W-1:0];
            r_duration    <= dur_ext[TIME_W-1:0];
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_note_pitch      = r_note_pitch;
    assign o_start_frame     = r_start_frame;
    assign o_duration_frames = r_duration;

`ifndef NO_ASSERTIONS
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_cmd == CMD_CLEAR)) |=> (r_ent_vld == '0 && r_fc == '0))
        else $error("clear did not reset per-pitch state");

    a_fc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_go && (r_s1_cmd == CMD_CLEAR)) |=> (r_fc >= $past(r_fc)))
        else $error("frame counter moved backward");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_emit) |=> o_out_valid)
        else $error("finished note not registered");

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_vld)
        else $error("forward flag without stage 1 item");
`endif

endmodule
